// File: hdl/lrk_pkg.sv
// Package for the Lorenz-63 RK4 trajectory generator: number formats,
// register indexes, microcode word layout, the microcode program and helpers.
// Used by lrk_seq, lrk_dp, the top level and the testbench; depends on nothing.
`default_nettype none

package lrk_pkg;

    // Number formats (all Q8.24 based).
    typedef logic signed [31:0] coord_t;   // coordinate / stage point
    typedef logic [30:0]        coef_t;    // sigma, rho, beta
    typedef logic [24:0]        step_t;    // integration step
    typedef logic signed [39:0] deriv_t;   // derivative, Q16.24
    typedef logic signed [43:0] wsum_t;    // weighted sum k1+2k2+2k3+k4
    typedef logic [43:0]        mag_t;     // magnitude in the divider
    typedef logic signed [65:0] prod_t;    // registered product / accumulator
    typedef logic [1:0]         lane_t;    // coordinate select x/y/z
    typedef logic [2:0]         stage_t;   // RK stage counter
    typedef logic [3:0]         pc_t;      // microcode step counter
    typedef logic [3:0]         loop_t;    // divider loop counter
    typedef logic [2:0]         rem_t;     // divider remainder

    // Reset values of the configuration registers.
    localparam coef_t  SIGMA_RESET = 31'd167772160;
    localparam coef_t  RHO_RESET   = 31'd469762048;
    localparam coef_t  BETA_RESET  = 31'd44739243;
    localparam step_t  STEP_RESET  = 25'd335544;
    localparam coord_t START_RESET = 32'sd16777216;
    localparam step_t  Q_ONE       = 25'd16777216;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_SIGMA   = 3'd0,
        REG_RHO     = 3'd1,
        REG_BETA    = 3'd2,
        REG_STEP    = 3'd3,
        REG_START_X = 3'd4,
        REG_START_Y = 3'd5,
        REG_START_Z = 3'd6
    } reg_idx_t;

    // RK stage numbering: stages 0..3 evaluate k1..k4, stage 4 is the final update.
    localparam stage_t STG_FIRST = 3'd0;
    localparam stage_t STG_FULL  = 3'd2;   // first stage that uses a whole step
    localparam stage_t STG_K4    = 3'd3;
    localparam stage_t STG_FINAL = 3'd4;

    // Divide by six, one nibble per step over a 44-bit magnitude.
    localparam int    DIV_NIBBLES = 11;
    localparam loop_t LOOP_INIT   = loop_t'(DIV_NIBBLES - 1);

    // Program labels.
    localparam pc_t PC_START = 4'd0;
    localparam pc_t PC_KX    = 4'd1;
    localparam pc_t PC_STAGE = 4'd5;
    localparam pc_t PC_DIV   = 4'd13;

    // Multiplier operand selection.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SIGMA,   // sigma * (y - x)
        MUL_RHO,     // x * (rho - z)
        MUL_XY,      // x * y
        MUL_BETA,    // beta * z
        MUL_KLO,     // low 16 bits of k * h
        MUL_KHI      // high 24 bits of k * h
    } mul_op_t;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,    // acc = product
        ACC_MAC      // acc = (product << 16) + acc
    } acc_op_t;

    // Register write operation.
    typedef enum logic [3:0] {
        WR_NONE,
        WR_KX,
        WR_KY,
        WR_T,
        WR_KZ,
        WR_PNT,      // stage point, or the new position in the final stage
        WR_DIVINIT,
        WR_DIVSTEP,
        WR_DIVEND
    } wr_op_t;

    // Sequencing operation.
    typedef enum logic [2:0] {
        SEQ_NEXT,
        SEQ_JUMP,
        SEQ_JUMP_K4,   // jump when the fourth derivative is done
        SEQ_LOOP,      // repeat this step until the loop counter runs out
        SEQ_FINISH     // end of a stage: stop after the final one, else jump
    } seq_op_t;

    typedef struct packed {
        mul_op_t mul;
        lane_t   ksel;
        acc_op_t acc;
        wr_op_t  wr;
        lane_t   wsel;
        logic    sum_en;
        logic    stage_inc;
        logic    cnt_load;
        seq_op_t seq;
        pc_t     target;
    } ucode_t;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        ucode_t uc;
        stage_t stage;
    } ctrl_t;

    localparam ucode_t UC_NOP = '{
        mul: MUL_NONE, ksel: 2'd0, acc: ACC_NONE, wr: WR_NONE, wsel: 2'd0,
        sum_en: 1'b0, stage_inc: 1'b0, cnt_load: 1'b0, seq: SEQ_NEXT, target: PC_START
    };

    // The microcode program. The product of a step is used by the next step.
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        w = UC_NOP;
        unique case (pc)
            4'd0:  begin w.mul = MUL_SIGMA; end
            4'd1:  begin w.mul = MUL_RHO;  w.wr = WR_KX; end
            4'd2:  begin w.mul = MUL_XY;   w.wr = WR_KY; end
            4'd3:  begin w.mul = MUL_BETA; w.wr = WR_T;  end
            4'd4:  begin w.wr = WR_KZ; end
            4'd5:
            begin
                w.mul = MUL_KLO; w.ksel = 2'd0; w.sum_en = 1'b1;
                w.seq = SEQ_JUMP_K4; w.target = PC_DIV;
            end
            4'd6:  begin w.mul = MUL_KHI; w.ksel = 2'd0; w.acc = ACC_LOAD; end
            4'd7:  begin w.mul = MUL_KLO; w.ksel = 2'd1; w.acc = ACC_MAC;  end
            4'd8:
            begin
                w.mul = MUL_KHI; w.ksel = 2'd1; w.acc = ACC_LOAD;
                w.wr = WR_PNT; w.wsel = 2'd0;
            end
            4'd9:  begin w.mul = MUL_KLO; w.ksel = 2'd2; w.acc = ACC_MAC; end
            4'd10:
            begin
                w.mul = MUL_KHI; w.ksel = 2'd2; w.acc = ACC_LOAD;
                w.wr = WR_PNT; w.wsel = 2'd1;
            end
            4'd11: begin w.acc = ACC_MAC; end
            4'd12:
            begin
                w.mul = MUL_SIGMA; w.wr = WR_PNT; w.wsel = 2'd2;
                w.stage_inc = 1'b1; w.seq = SEQ_FINISH; w.target = PC_KX;
            end
            4'd13: begin w.wr = WR_DIVINIT; w.cnt_load = 1'b1; end
            4'd14: begin w.wr = WR_DIVSTEP; w.seq = SEQ_LOOP; end
            4'd15:
            begin
                w.wr = WR_DIVEND; w.stage_inc = 1'b1;
                w.seq = SEQ_JUMP; w.target = PC_STAGE;
            end
            default: w = UC_NOP;
        endcase
        return w;
    endfunction

    // Saturate a 43-bit value to the derivative range.
    function automatic deriv_t sat40(input logic signed [42:0] v);
        deriv_t r;
        if (v[42:39] == {4{v[42]}})
            r = v[39:0];
        else
            r = v[42] ? {1'b1, {39{1'b0}}} : {1'b0, {39{1'b1}}};
        return r;
    endfunction

    // Saturate a 43-bit value to the coordinate range.
    function automatic coord_t sat32(input logic signed [42:0] v);
        coord_t r;
        if (v[42:31] == {12{v[42]}})
            r = v[31:0];
        else
            r = v[42] ? {1'b1, {31{1'b0}}} : {1'b0, {31{1'b1}}};
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [42:0] v);
        return v[42:31] != {12{v[42]}};
    endfunction

    // One radix-16 digit of a division by six: v = remainder * 16 + next nibble.
    // q = floor(v * 43 / 256) is exact for v below 128.
    typedef struct packed {
        logic [3:0] q;
        rem_t       r;
    } div6_t;

    function automatic div6_t div6_digit(input logic [6:0] v);
        logic [12:0] scaled;
        logic [6:0]  six_q;
        div6_t       d;
        scaled = 13'(v) * 13'd43;
        d.q    = scaled[11:8];
        six_q  = {1'b0, d.q, 2'b00} + {2'b00, d.q, 1'b0};
        d.r    = 3'(v - six_q);
        return d;
    endfunction

endpackage

`default_nettype wire

// File: hdl/lrk_seq.sv
// Microcode sequencer: step counter, RK stage counter and loop counter,
// stepping through the program held in lrk_pkg::ucode_rom.
// Depends on lrk_pkg.
`default_nettype none

module lrk_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output lrk_pkg::ctrl_t     ctrl
);
    import lrk_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

    seq_state_t state_reg, state_next;
    pc_t        pc_reg, pc_next;
    stage_t     stage_reg, stage_next;
    loop_t      cnt_reg, cnt_next;
    ucode_t     uc;

    // Next step selection.
    always_comb
    begin
        uc         = ucode_rom(pc_reg);
        state_next = state_reg;
        pc_next    = pc_reg;
        stage_next = stage_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                    pc_next    = PC_START;
                    stage_next = STG_FIRST;
                end
            end
            ST_RUN:
            begin
                if (uc.stage_inc)
                    stage_next = stage_reg + 3'd1;
                if (uc.cnt_load)
                    cnt_next = LOOP_INIT;
                unique case (uc.seq)
                    SEQ_NEXT: pc_next = pc_reg + 4'd1;
                    SEQ_JUMP: pc_next = uc.target;
                    SEQ_JUMP_K4:
                    begin
                        if (stage_reg == STG_K4)
                            pc_next = uc.target;
                        else
                            pc_next = pc_reg + 4'd1;
                    end
                    SEQ_LOOP:
                    begin
                        if (cnt_reg != '0)
                            cnt_next = cnt_reg - 4'd1;
                        else
                            pc_next = pc_reg + 4'd1;
                    end
                    SEQ_FINISH:
                    begin
                        if (stage_reg == STG_FINAL)
                            state_next = ST_IDLE;
                        else
                            pc_next = uc.target;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= PC_START;
            stage_reg <= STG_FIRST;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            stage_reg <= stage_next;
            cnt_reg   <= cnt_next;
        end
    end

    // The datapath sees no operation while the sequencer is idle.
    assign busy       = (state_reg == ST_RUN);
    assign ctrl.uc    = busy ? uc : UC_NOP;
    assign ctrl.stage = stage_reg;

endmodule

`default_nettype wire

// File: hdl/lrk_dp.sv
// Datapath: position, stage point, derivative and sum registers, one shared
// 34x34 multiplier with registered product, accumulator and a divide-by-six unit.
// Depends on lrk_pkg; driven by the control word from lrk_seq.
`default_nettype none

module lrk_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lrk_pkg::ctrl_t ctrl,
    input  wire logic           launch,
    input  wire lrk_pkg::coord_t init_x,
    input  wire lrk_pkg::coord_t init_y,
    input  wire lrk_pkg::coord_t init_z,
    input  wire lrk_pkg::coef_t  sigma,
    input  wire lrk_pkg::coef_t  rho,
    input  wire lrk_pkg::coef_t  beta,
    input  wire lrk_pkg::step_t  step,
    output lrk_pkg::coord_t      pos_x,
    output lrk_pkg::coord_t      pos_y,
    output lrk_pkg::coord_t      pos_z,
    output logic                 clip
);
    import lrk_pkg::*;

    coord_t s_reg [3];
    coord_t p_reg [3];
    deriv_t k_reg [3];
    wsum_t  sum_reg [3];
    mag_t   mag_reg [3];
    rem_t   rem_reg [3];
    logic   neg_reg [3];
    logic signed [41:0] t_reg;
    prod_t  prod_reg;
    prod_t  acc_reg;
    step_t  h_reg;
    logic   clip_reg;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;
    logic signed [41:0] prod_sh;
    logic signed [42:0] ky_diff, kz_diff;
    logic signed [41:0] acc_sh;
    logic signed [42:0] pnt_sum;
    coord_t             pnt_val;
    logic               pnt_ovf;
    logic               final_stage;
    deriv_t             k_sel;
    div6_t              dig [3];

    assign final_stage = (ctrl.stage == STG_FINAL);
    assign k_sel       = k_reg[ctrl.uc.ksel];

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.uc.mul)
            MUL_NONE:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            MUL_SIGMA:
            begin
                mul_a = $signed({3'b000, sigma});
                mul_b = 34'(p_reg[1]) - 34'(p_reg[0]);
            end
            MUL_RHO:
            begin
                mul_a = 34'(p_reg[0]);
                mul_b = $signed({3'b000, rho}) - 34'(p_reg[2]);
            end
            MUL_XY:
            begin
                mul_a = 34'(p_reg[0]);
                mul_b = 34'(p_reg[1]);
            end
            MUL_BETA:
            begin
                mul_a = $signed({3'b000, beta});
                mul_b = 34'(p_reg[2]);
            end
            MUL_KLO:
            begin
                mul_a = $signed({18'd0, k_sel[15:0]});
                mul_b = $signed({9'd0, h_reg});
            end
            MUL_KHI:
            begin
                mul_a = 34'($signed(k_sel[39:16]));
                mul_b = $signed({9'd0, h_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Derivative arithmetic on the registered product, floor of the Q.24 shift.
    assign prod_sh = prod_reg[65:24];
    assign ky_diff = {prod_sh[41], prod_sh} - 43'(p_reg[1]);
    assign kz_diff = {t_reg[41], t_reg} - {prod_sh[41], prod_sh};

    // Stage point: s + floor(k*h / 2^25) for half steps, / 2^24 for whole steps.
    assign acc_sh  = (ctrl.stage < STG_FULL) ? {acc_reg[65], acc_reg[65:25]} : acc_reg[65:24];
    assign pnt_sum = 43'(s_reg[ctrl.uc.wsel]) + {acc_sh[41], acc_sh};
    assign pnt_val = sat32(pnt_sum);
    assign pnt_ovf = ovf32(pnt_sum);

    // Next quotient digit and remainder of each divider lane.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            dig[i] = div6_digit({rem_reg[i], mag_reg[i][43:40]});
    end

    // Position and clip flag keep their values across items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                s_reg[i] <= START_RESET;
            clip_reg <= 1'b0;
        end
        else if (launch)
        begin
            s_reg[0] <= init_x;
            s_reg[1] <= init_y;
            s_reg[2] <= init_z;
            clip_reg <= 1'b0;
        end
        else if (ctrl.uc.wr == WR_PNT && final_stage)
        begin
            s_reg[ctrl.uc.wsel] <= pnt_val;
            clip_reg            <= clip_reg | pnt_ovf;
        end
    end

    // Product, accumulator and step size.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p[65:0];
        if (launch)
            h_reg <= (step > Q_ONE) ? Q_ONE : step;
        unique case (ctrl.uc.acc)
            ACC_NONE: acc_reg <= acc_reg;
            ACC_LOAD: acc_reg <= prod_reg;
            ACC_MAC:  acc_reg <= (prod_reg <<< 16) + acc_reg;
            default:  acc_reg <= acc_reg;
        endcase
    end

    // Stage points, derivatives and the divider lanes.
    always_ff @(posedge clk)
    begin
        if (launch)
        begin
            p_reg[0] <= init_x;
            p_reg[1] <= init_y;
            p_reg[2] <= init_z;
        end
        unique case (ctrl.uc.wr)
            WR_NONE: ;
            WR_KX:   k_reg[0] <= sat40({prod_sh[41], prod_sh});
            WR_KY:   k_reg[1] <= sat40(ky_diff);
            WR_T:    t_reg    <= prod_sh;
            WR_KZ:   k_reg[2] <= sat40(kz_diff);
            WR_PNT:
            begin
                if (!final_stage)
                    p_reg[ctrl.uc.wsel] <= pnt_val;
            end
            WR_DIVINIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= sum_reg[i][43];
                    mag_reg[i] <= sum_reg[i][43] ? mag_t'(-sum_reg[i]) : mag_t'(sum_reg[i]);
                    rem_reg[i] <= '0;
                end
            end
            WR_DIVSTEP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= {mag_reg[i][39:0], dig[i].q};
                    rem_reg[i] <= dig[i].r;
                end
            end
            WR_DIVEND:
            begin
                for (int i = 0; i < 3; i++)
                    k_reg[i] <= neg_reg[i] ? -$signed(mag_reg[i][39:0])
                                           : $signed(mag_reg[i][39:0]);
            end
            default: ;
        endcase
    end

    // Weighted derivative sum: k1 + 2*k2 + 2*k3 + k4.
    always_ff @(posedge clk)
    begin
        if (ctrl.uc.sum_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                unique case (ctrl.stage)
                    3'd0:    sum_reg[i] <= 44'(k_reg[i]);
                    3'd1,
                    3'd2:    sum_reg[i] <= sum_reg[i] + (44'(k_reg[i]) <<< 1);
                    3'd3:    sum_reg[i] <= sum_reg[i] + 44'(k_reg[i]);
                    default: sum_reg[i] <= sum_reg[i];
                endcase
            end
        end
    end

    assign pos_x = s_reg[0];
    assign pos_y = s_reg[1];
    assign pos_z = s_reg[2];
    assign clip  = clip_reg;

endmodule

`default_nettype wire

// File: hdl/lorenz_rk4_generator_unit.sv
// Top level of the Lorenz-63 RK4 trajectory generator: configuration
// registers, input and output handshakes, output register.
// Depends on lrk_pkg, lrk_seq and lrk_dp.
`default_nettype none

// Each accepted input transfer emits the current point (x, y, z) with the clip
// flag of the step that produced it, after first restoring the configured
// start point when reload is set, and then advances the point by one
// fourth-order Runge-Kutta step of the Lorenz-63 system in signed Q8.24.
// An item occupies the block for the accept cycle plus a 63-step microcode
// program that runs all products through one shared 34x34 multiplier and
// divides the weighted derivative sum by six one nibble per cycle. The
// result sits in an output register, so the advance runs while the result
// waits; in_ready rises again once the program ends and the output register
// is free or being emptied. Writes to the start point take effect at the
// next reload; a step size above 1.0 acts as 1.0.
module lorenz_rk4_generator_unit (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [31:0]     cfg_wdata,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic            reload,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output lrk_pkg::coord_t      coord_x,
    output lrk_pkg::coord_t      coord_y,
    output lrk_pkg::coord_t      coord_z,
    output logic                 saturated
);
    import lrk_pkg::*;

    coef_t  sigma_reg, rho_reg, beta_reg;
    step_t  step_reg;
    coord_t start_x_reg, start_y_reg, start_z_reg;
    coord_t coord_x_reg, coord_y_reg, coord_z_reg;
    logic   saturated_reg;
    logic   out_valid_reg;

    logic   busy;
    logic   in_xfer;
    ctrl_t  ctrl;
    coord_t pos_x, pos_y, pos_z;
    logic   clip;
    coord_t emit_x, emit_y, emit_z;
    logic   emit_sat;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sigma_reg   <= SIGMA_RESET;
            rho_reg     <= RHO_RESET;
            beta_reg    <= BETA_RESET;
            step_reg    <= STEP_RESET;
            start_x_reg <= START_RESET;
            start_y_reg <= START_RESET;
            start_z_reg <= START_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SIGMA:   sigma_reg   <= cfg_wdata[30:0];
                REG_RHO:     rho_reg     <= cfg_wdata[30:0];
                REG_BETA:    beta_reg    <= cfg_wdata[30:0];
                REG_STEP:    step_reg    <= cfg_wdata[24:0];
                REG_START_X: start_x_reg <= cfg_wdata;
                REG_START_Y: start_y_reg <= cfg_wdata;
                REG_START_Z: start_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input transfer: take an item once the program is done and the output is free or being emptied.
    assign in_ready = !busy && (!out_valid_reg || out_ready);
    assign in_xfer  = in_valid && in_ready;

    // The point emitted for this item, and the point the step starts from.
    assign emit_x   = reload ? start_x_reg : pos_x;
    assign emit_y   = reload ? start_y_reg : pos_y;
    assign emit_z   = reload ? start_z_reg : pos_z;
    assign emit_sat = reload ? 1'b0 : clip;

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            coord_x_reg   <= emit_x;
            coord_y_reg   <= emit_y;
            coord_z_reg   <= emit_z;
            saturated_reg <= emit_sat;
        end
    end

    lrk_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_xfer),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    lrk_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .launch (in_xfer),
        .init_x (emit_x),
        .init_y (emit_y),
        .init_z (emit_z),
        .sigma  (sigma_reg),
        .rho    (rho_reg),
        .beta   (beta_reg),
        .step   (step_reg),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .clip   (clip)
    );

    assign out_valid = out_valid_reg;
    assign coord_x   = coord_x_reg;
    assign coord_y   = coord_y_reg;
    assign coord_z   = coord_z_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire

// File: hdl/lrk_checker.sv
// Port-level checker for lorenz_rk4_generator_unit, with the bind that
// attaches it to the top level. Depends only on the top level's ports.
`default_nettype none

module lrk_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        reload,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] coord_x,
    input wire logic [31:0] coord_y,
    input wire logic [31:0] coord_z,
    input wire logic        saturated
);

    // Every input transfer produces a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
    else $error("no result after an input transfer");

    // The step runs over many cycles, so no second item is taken right away.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a step is in progress");

    // A reload restores the start point and clears the clip flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && reload) |=> !saturated)
    else $error("clip flag set on a reloaded point");

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(coord_x) && $stable(coord_y)
             && $stable(coord_z) && $stable(saturated)))
    else $error("stalled result changed");

endmodule

bind lorenz_rk4_generator_unit lrk_checker u_lrk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .reload    (reload),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .coord_z   (coord_z),
    .saturated (saturated)
);

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for lorenz_rk4_generator_unit: a bit-exact RK4 trajectory predictor
// in a small scoreboard class checks every emitted point for directed and random ticks.
// Depends on lrk_pkg and the RTL of the block; it reads no files.

module tb;
    import lrk_pkg::*;

    localparam int         IDLE_MAX      = 14;
    localparam int         SETTLE_CYCLES = 70;
    localparam int         STALL_LIMIT   = 1000;
    localparam int         RANDOM_ITEMS  = 650;
    localparam int         RANDOM_PHASES = 9;
    localparam logic [2:0] REG_UNUSED    = 3'd7;
    localparam longint     Q1            = 64'sd16777216;

    typedef longint vec3_t [3];

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   clip;
    } point_t;

    // Tracks the trajectory the block should produce and checks each emitted point.
    class trajectory_scoreboard;
        longint sigma, rho, beta, dt;
        longint start_pt [3];
        longint pos [3];
        bit     clip_flag;
        point_t expected_points [$];
        int     errors, inputs, reloads, checked, clipped;

        function new();
            sigma = SIGMA_RESET;
            rho   = RHO_RESET;
            beta  = BETA_RESET;
            dt    = STEP_RESET;
            foreach (pos[i])
            begin
                start_pt[i] = START_RESET;
                pos[i]      = START_RESET;
            end
            clip_flag = 1'b0;
        endfunction

        // Register writes are masked to the register widths; unknown indexes are dropped.
        function void write_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_SIGMA:   sigma = longint'(d[30:0]);
                REG_RHO:     rho   = longint'(d[30:0]);
                REG_BETA:    beta  = longint'(d[30:0]);
                REG_STEP:    dt    = longint'(d[24:0]);
                REG_START_X: start_pt[0] = coord_t'(d);
                REG_START_Y: start_pt[1] = coord_t'(d);
                REG_START_Z: start_pt[2] = coord_t'(d);
                default: ;
            endcase
        endfunction

        function longint saturate(longint v, int bits, inout bit hit);
            longint lim;
            lim = 64'sd1 <<< (bits - 1);
            if (v > lim - 1)
            begin
                hit = 1'b1;
                return lim - 1;
            end
            if (v < -lim)
            begin
                hit = 1'b1;
                return -lim;
            end
            return v;
        endfunction

        // Lorenz-63 derivatives in Q16.24, each clipped to 40 bits.
        function void lorenz_rates(input vec3_t p, output vec3_t k);
            bit ignore;
            ignore = 1'b0;
            k[0] = saturate((sigma * (p[1] - p[0])) >>> 24, 40, ignore);
            k[1] = saturate(((p[0] * (rho - p[2])) >>> 24) - p[1], 40, ignore);
            k[2] = saturate(((p[0] * p[1]) >>> 24) - ((beta * p[2]) >>> 24), 40, ignore);
        endfunction

        function void stage_point(input vec3_t s, input vec3_t k, input longint h,
                                  input int sh, output vec3_t o);
            bit ignore;
            ignore = 1'b0;
            foreach (o[i])
                o[i] = saturate(s[i] + ((k[i] * h) >>> sh), 32, ignore);
        endfunction

        // One classic RK4 step; only the final coordinate clip sets the flag.
        function void rk4_advance();
            vec3_t  s, p, k1, k2, k3, k4;
            longint h, m;
            bit     ignore, hit;
            ignore = 1'b0;
            hit    = 1'b0;
            h      = (dt > Q1) ? Q1 : dt;
            s      = pos;
            lorenz_rates(s, k1);
            stage_point(s, k1, h, 25, p);
            lorenz_rates(p, k2);
            stage_point(s, k2, h, 25, p);
            lorenz_rates(p, k3);
            stage_point(s, k3, h, 24, p);
            lorenz_rates(p, k4);
            for (int i = 0; i < 3; i++)
            begin
                m    = (k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i]) / 6;
                m    = saturate(m, 40, ignore);
                s[i] = saturate(s[i] + ((m * h) >>> 24), 32, hit);
            end
            pos       = s;
            clip_flag = hit;
        endfunction

        // An accepted tick emits the current point, then the point advances.
        function void note_input(logic rl);
            point_t e;
            inputs++;
            if (rl)
            begin
                reloads++;
                pos       = start_pt;
                clip_flag = 1'b0;
            end
            e.x    = coord_t'(pos[0]);
            e.y    = coord_t'(pos[1]);
            e.z    = coord_t'(pos[2]);
            e.clip = clip_flag;
            expected_points.push_back(e);
            rk4_advance();
        endfunction

        function void check_result(coord_t x, coord_t y, coord_t z, logic sat);
            point_t e;
            if (expected_points.size() == 0)
            begin
                $error("point transfer with nothing expected: x=%0d y=%0d z=%0d", x, y, z);
                errors++;
                return;
            end
            e = expected_points.pop_front();
            checked++;
            if (e.clip)
                clipped++;
            if (x !== e.x)
            begin
                $error("coord_x mismatch: expected %0d, got %0d", e.x, x);
                errors++;
            end
            if (y !== e.y)
            begin
                $error("coord_y mismatch: expected %0d, got %0d", e.y, y);
                errors++;
            end
            if (z !== e.z)
            begin
                $error("coord_z mismatch: expected %0d, got %0d", e.z, z);
                errors++;
            end
            if (sat !== e.clip)
            begin
                $error("saturated mismatch: expected %0b, got %0b", e.clip, sat);
                errors++;
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_wdata = 32'd0;
    logic        in_valid  = 1'b0;
    logic        reload    = 1'b0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    coord_t      coord_x, coord_y, coord_z;
    logic        saturated;

    trajectory_scoreboard sb;
    int rx_stall     = 0;
    int quiet_cycles = 0;
    int settings     = 1;
    bit rx_idle_on   = 1'b0;
    bit tx_idle_on   = 1'b0;

    lorenz_rk4_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .reload    (reload),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .saturated (saturated)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // The receiver holds ready low for the drawn number of cycles before each transfer.
    always @(negedge clk)
    begin
        if (rx_stall > 0)
        begin
            out_ready <= 1'b0;
            rx_stall = rx_stall - 1;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Check every result transfer and draw the stall for the next one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(coord_x, coord_y, coord_z, saturated);
            rx_stall = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        end
    end

    // Stop the run if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles, %0d points outstanding",
                         STALL_LIMIT, sb.pending());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Registers narrower than the port sometimes get random junk in the unused upper bits.
    function automatic logic [31:0] with_junk(logic [31:0] v, int width);
        if ($urandom_range(0, 1))
            v = v | ($urandom << width);
        return v;
    endfunction

    function automatic logic [31:0] pick_coef(logic [31:0] typical_max, bit wild);
        if (!wild)
            return $urandom_range(0, typical_max);
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom & 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [31:0] pick_start(bit wild);
        if (!wild)
            return $urandom_range(0, 40 << 24) - (20 << 24);
        case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] d);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, d);
    endtask

    // One tick transfer, after an optional gap with junk on reload.
    task automatic send_tick(logic rl);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            reload   <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        reload   <= rl;
        do @(posedge clk); while (!in_ready);
        sb.note_input(rl);
    endtask

    // Stop sending, wait for every expected point, then let the advance finish.
    task automatic drain(int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // A new register setting: mostly a plausible attractor, sometimes extreme values.
    task automatic random_setting();
        bit          wild;
        logic [31:0] step_v;
        wild = ($urandom_range(0, 9) < 3);
        if (!wild)
            step_v = $urandom_range(0, 838860);
        else
            case ($urandom_range(0, 3))
                0:       step_v = 32'd0;
                1:       step_v = 32'(Q_ONE);
                2:       step_v = $urandom_range(32'(Q_ONE) + 1, 32'h01FF_FFFF);
                default: step_v = $urandom_range(0, 32'h01FF_FFFF);
            endcase
        write_reg(REG_SIGMA, with_junk(pick_coef(20 << 24, wild), 31));
        write_reg(REG_RHO, with_junk(pick_coef(50 << 24, wild), 31));
        write_reg(REG_BETA, with_junk(pick_coef(4 << 24, wild), 31));
        write_reg(REG_STEP, with_junk(step_v, 25));
        write_reg(REG_START_X, pick_start(wild));
        write_reg(REG_START_Y, pick_start(wild));
        write_reg(REG_START_Z, pick_start(wild));
        if ($urandom_range(0, 2) == 0)
            write_reg(REG_UNUSED, $urandom);
        settings++;
    endtask

    initial
    begin
        int  per_phase;
        bit  rl;
        sb = new();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Reset setting: plain ticks, a reload, and ticks after it.
        repeat (3) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain(SETTLE_CYCLES);

        // Largest coefficients, a step above 1.0 and extreme start points: heavy clipping.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        write_reg(REG_SIGMA, 32'hFFFF_FFFF);
        write_reg(REG_RHO, 32'h7FFF_FFFF);
        write_reg(REG_BETA, 32'h7FFF_FFFF);
        write_reg(REG_STEP, 32'h01FF_FFFF);
        write_reg(REG_START_X, 32'h7FFF_FFFF);
        write_reg(REG_START_Y, 32'h8000_0000);
        write_reg(REG_START_Z, 32'h7FFF_FFFF);
        settings++;
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        drain(SETTLE_CYCLES);

        // All coefficients and the step at zero, start at the negative limit.
        write_reg(REG_SIGMA, 32'd0);
        write_reg(REG_RHO, 32'd0);
        write_reg(REG_BETA, 32'd0);
        write_reg(REG_STEP, 32'd0);
        write_reg(REG_START_X, 32'h8000_0000);
        write_reg(REG_START_Y, 32'h8000_0000);
        write_reg(REG_START_Z, 32'h8000_0000);
        settings++;
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
        drain(SETTLE_CYCLES);

        // Default coefficients with a step of exactly 1.0; the new start point
        // must not show until the reload, and the unused index is ignored.
        write_reg(REG_SIGMA, 32'(SIGMA_RESET));
        write_reg(REG_RHO, 32'(RHO_RESET));
        write_reg(REG_BETA, 32'(BETA_RESET));
        write_reg(REG_STEP, 32'(Q_ONE));
        write_reg(REG_START_X, 32'hFB00_0000);
        write_reg(REG_START_Y, 32'h0300_0000);
        write_reg(REG_START_Z, 32'h1400_0000);
        write_reg(REG_UNUSED, 32'h5A5A_5A5A);
        settings++;
        send_tick(1'b0);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        drain(SETTLE_CYCLES);

        // Random phases: long trajectories with occasional reloads and drained pauses.
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_setting();
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < per_phase; n++)
            begin
                if (n == 0)
                    rl = ($urandom_range(0, 4) != 0);
                else
                    rl = ($urandom_range(0, 99) < 6);
                if (n > 0 && $urandom_range(0, 49) == 0)
                    drain(0);
                send_tick(rl);
            end
            drain(SETTLE_CYCLES);
        end

        $display("Covered %0d ticks (%0d with reload) over %0d register settings.",
                 sb.inputs, sb.reloads, settings);
        $display("Checked %0d points, %0d of them flagged as clipped.", sb.checked, sb.clipped);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
